// ----- design/i2cem_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C EEPROM sequencer package
// Shared types and codes for the I2C EEPROM byte write and random read master.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cem_pkg;

   // Request kinds carried in the input beat.
   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

   // Configuration register indexes.
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 24;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_DEVICE_ADDRESS   = 1'b0,
      CSR_WRITE_WAIT_TICKS = 1'b1
   } csr_index_type;

   // Register reset values.
   localparam logic [6:0]  DEVICE_ADDRESS_RESET   = 7'h50;
   localparam logic [23:0] WRITE_WAIT_TICKS_RESET = 24'd100000;

   // Last bit position of a byte, most significant bit first.
   localparam logic [2:0] BIT_LAST = 3'd7;

   // Sequencer phases, one-hot.
   typedef enum logic [13:0] {
      PH_IDLE      = 14'b00000000000001,
      PH_SEND_DEV  = 14'b00000000000010,
      PH_ACK_DEV   = 14'b00000000000100,
      PH_SEND_ADDR = 14'b00000000001000,
      PH_ACK_ADDR  = 14'b00000000010000,
      PH_SEND_DATA = 14'b00000000100000,
      PH_ACK_DATA  = 14'b00000001000000,
      PH_RESTART   = 14'b00000010000000,
      PH_SEND_RDEV = 14'b00000100000000,
      PH_ACK_RDEV  = 14'b00001000000000,
      PH_READ      = 14'b00010000000000,
      PH_NACK      = 14'b00100000000000,
      PH_STOP      = 14'b01000000000000,
      PH_WAIT      = 14'b10000000000000
   } phase_type;

   // Input beat.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] mem_address;
      logic [7:0] write_data;
      logic       sda_in;
   } req_payload_type;

   // Result beat.
   typedef struct packed {
      logic       scl;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       rejected;
   } rsp_payload_type;

   // Configuration handed to the sequencer.
   typedef struct packed {
      logic [6:0]  device_address;
      logic [23:0] write_wait_ticks;
   } cfg_type;

endpackage

`default_nettype wire

// ----- design/i2cem_seq.sv -----
// ----------------------------------------------------------------------------
// I2C EEPROM line sequencer
// Holds the transaction state and advances one line step for each beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cem_seq (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      step,
   input  wire i2cem_pkg::req_payload_type req,
   input  wire i2cem_pkg::cfg_type        cfg,
   output i2cem_pkg::rsp_payload_type     rsp
);
   import i2cem_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  bit_index_ff, bit_index_in;
   logic [7:0]  shift_byte_ff, shift_byte_in;
   logic [23:0] wait_count_ff, wait_count_in;
   logic        is_read_ff, is_read_in;
   logic [7:0]  latched_address_ff, latched_address_in;
   logic [7:0]  latched_data_ff, latched_data_in;
   logic [7:0]  read_byte_ff, read_byte_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic        done;
   logic        rejected;
   logic        request;

   assign request = (req.kind == KIND_WRITE) || (req.kind == KIND_READ);

   // Next-state logic for one line step.
   always_comb begin
      phase_in           = phase_ff;
      bit_index_in       = bit_index_ff;
      shift_byte_in      = shift_byte_ff;
      wait_count_in      = wait_count_ff;
      is_read_in         = is_read_ff;
      latched_address_in = latched_address_ff;
      latched_data_in    = latched_data_ff;
      read_byte_in       = read_byte_ff;
      scl_in             = scl_ff;
      sda_in             = sda_ff;
      done               = 1'b0;
      rejected           = 1'b0;

      if (request && (phase_ff == PH_IDLE)) begin
         // Start condition: SDA falls while SCL stays high.
         latched_address_in = req.mem_address;
         latched_data_in    = req.write_data;
         is_read_in         = (req.kind == KIND_READ);
         scl_in             = 1'b1;
         sda_in             = 1'b0;
         phase_in           = PH_SEND_DEV;
         shift_byte_in      = {cfg.device_address, 1'b0};
         bit_index_in       = 3'd0;
      end else begin
         rejected = request;
         case (phase_ff)
            PH_SEND_DEV, PH_SEND_ADDR, PH_SEND_DATA, PH_SEND_RDEV: begin
               if (scl_ff) begin
                  scl_in = 1'b0;
                  sda_in = shift_byte_ff[~bit_index_ff];
               end else begin
                  scl_in = 1'b1;
                  if (bit_index_ff == BIT_LAST) begin
                     bit_index_in = 3'd0;
                     case (phase_ff)
                        PH_SEND_DEV:  phase_in = PH_ACK_DEV;
                        PH_SEND_ADDR: phase_in = PH_ACK_ADDR;
                        PH_SEND_DATA: phase_in = PH_ACK_DATA;
                        default:      phase_in = PH_ACK_RDEV;
                     endcase
                  end else begin
                     bit_index_in = bit_index_ff + 3'd1;
                  end
               end
            end
            PH_ACK_DEV, PH_ACK_ADDR, PH_ACK_DATA, PH_ACK_RDEV: begin
               if (bit_index_ff == 3'd0) begin
                  scl_in       = 1'b0;
                  sda_in       = 1'b1;
                  bit_index_in = 3'd1;
               end else if (bit_index_ff == 3'd1) begin
                  scl_in       = 1'b1;
                  bit_index_in = 3'd2;
               end else if (!req.sda_in) begin
                  // Acknowledge seen: move on, lines unchanged.
                  bit_index_in = 3'd0;
                  case (phase_ff)
                     PH_ACK_DEV: begin
                        phase_in      = PH_SEND_ADDR;
                        shift_byte_in = latched_address_ff;
                     end
                     PH_ACK_ADDR: begin
                        if (is_read_ff) begin
                           phase_in = PH_RESTART;
                        end else begin
                           phase_in      = PH_SEND_DATA;
                           shift_byte_in = latched_data_ff;
                        end
                     end
                     PH_ACK_DATA: begin
                        phase_in = PH_STOP;
                     end
                     default: begin
                        phase_in     = PH_READ;
                        read_byte_in = 8'd0;
                     end
                  endcase
               end
            end
            PH_RESTART: begin
               if (bit_index_ff == 3'd0) begin
                  scl_in       = 1'b0;
                  sda_in       = 1'b1;
                  bit_index_in = 3'd1;
               end else if (bit_index_ff == 3'd1) begin
                  scl_in       = 1'b1;
                  bit_index_in = 3'd2;
               end else begin
                  sda_in        = 1'b0;
                  phase_in      = PH_SEND_RDEV;
                  shift_byte_in = {cfg.device_address, 1'b1};
                  bit_index_in  = 3'd0;
               end
            end
            PH_READ: begin
               if (scl_ff) begin
                  scl_in = 1'b0;
                  sda_in = 1'b1;
               end else begin
                  scl_in = 1'b1;
                  if (req.sda_in) begin
                     read_byte_in[~bit_index_ff] = 1'b1;
                  end
                  if (bit_index_ff == BIT_LAST) begin
                     phase_in     = PH_NACK;
                     bit_index_in = 3'd0;
                  end else begin
                     bit_index_in = bit_index_ff + 3'd1;
                  end
               end
            end
            PH_NACK: begin
               if (bit_index_ff == 3'd0) begin
                  scl_in       = 1'b0;
                  sda_in       = 1'b1;
                  bit_index_in = 3'd1;
               end else begin
                  scl_in       = 1'b1;
                  phase_in     = PH_STOP;
                  bit_index_in = 3'd0;
               end
            end
            PH_STOP: begin
               if (bit_index_ff == 3'd0) begin
                  scl_in       = 1'b0;
                  sda_in       = 1'b0;
                  bit_index_in = 3'd1;
               end else if (bit_index_ff == 3'd1) begin
                  scl_in       = 1'b1;
                  bit_index_in = 3'd2;
               end else begin
                  sda_in       = 1'b1;
                  bit_index_in = 3'd0;
                  if (is_read_ff) begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end else begin
                     phase_in      = PH_WAIT;
                     wait_count_in = cfg.write_wait_ticks;
                  end
               end
            end
            PH_WAIT: begin
               // The EEPROM write cycle runs down before the block frees.
               if (wait_count_ff == 24'd0) begin
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end else begin
                  wait_count_in = wait_count_ff - 24'd1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // State registers, advanced once per processed beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_IDLE;
         bit_index_ff       <= 3'd0;
         shift_byte_ff      <= 8'd0;
         wait_count_ff      <= 24'd0;
         is_read_ff         <= 1'b0;
         latched_address_ff <= 8'd0;
         latched_data_ff    <= 8'd0;
         read_byte_ff       <= 8'd0;
         scl_ff             <= 1'b1;
         sda_ff             <= 1'b1;
      end else if (step) begin
         phase_ff           <= phase_in;
         bit_index_ff       <= bit_index_in;
         shift_byte_ff      <= shift_byte_in;
         wait_count_ff      <= wait_count_in;
         is_read_ff         <= is_read_in;
         latched_address_ff <= latched_address_in;
         latched_data_ff    <= latched_data_in;
         read_byte_ff       <= read_byte_in;
         scl_ff             <= scl_in;
         sda_ff             <= sda_in;
      end
   end

   // Result beat taken from the state after this step.
   always_comb begin
      rsp.scl       = scl_in;
      rsp.sda_drive = sda_in;
      rsp.busy_res  = (phase_in != PH_IDLE);
      rsp.done_res  = done;
      rsp.read_data = read_byte_in;
      rsp.rejected  = rejected;
   end

endmodule

`default_nettype wire

// ----- design/i2c_eeprom_master_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// I2C EEPROM master sequencer
// Byte write and random read master for a serial EEPROM, one line step a beat.
// ----------------------------------------------------------------------------
//
//   Port group   Direction   Handshake          Contents
//   req_*        in          valid / stall      kind, address, data, SDA sample
//   rsp_*        out         valid / stall      SCL, SDA, busy, done, read data
//   csr_*        in          write enable only  device address, write wait
//
// One beat is accepted in every cycle unless req_stall holds it; each beat gives
// one result beat, passing through the input register and then the result register.
// The sequencer state moves only when a beat passes from the input register
// into the result register, so a stalled result holds back the state.
// Reset is synchronous and returns the lines to released high and idle.
// While the result waits, one further beat is taken into the input register.
//
`timescale 1ns / 1ps
`default_nettype none

module i2c_eeprom_master_sequencer_top (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_valid,
   output logic                                           req_stall,
   input  wire i2cem_pkg::req_payload_type                req_payload,
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_stall,
   output i2cem_pkg::rsp_payload_type                     rsp_payload,
   input  wire logic                                      csr_write,
   input  wire logic [i2cem_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire logic [i2cem_pkg::CSR_DATA_WIDTH-1:0]      csr_data
);
   import i2cem_pkg::*;

   logic            in_valid_ff;
   req_payload_type in_payload_ff;
   logic            out_valid_ff;
   rsp_payload_type out_payload_ff;
   cfg_type         cfg_ff;
   rsp_payload_type result;
   logic            advance;

   // A held beat moves on when the result register is free or draining.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address   <= DEVICE_ADDRESS_RESET;
         cfg_ff.write_wait_ticks <= WRITE_WAIT_TICKS_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DEVICE_ADDRESS:   cfg_ff.device_address   <= csr_data[6:0];
            CSR_WRITE_WAIT_TICKS: cfg_ff.write_wait_ticks <= csr_data[23:0];
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_payload_ff <= req_payload;
      end
   end

   i2cem_seq u_seq (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (in_payload_ff),
      .cfg   (cfg_ff),
      .rsp   (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_payload_ff <= result;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_payload_ff;

endmodule

`default_nettype wire

// ----- design/i2cem_checker.sv -----
// ----------------------------------------------------------------------------
// I2C EEPROM sequencer checker
// Port-level checks on the result stream of the sequencer top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cem_checker (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   input  wire i2cem_pkg::rsp_payload_type            rsp_payload
);
   import i2cem_pkg::*;

   logic rsp_beat;
   logic last_busy_ff;

   assign rsp_beat = rsp_valid && !rsp_stall;

   // Busy flag of the last delivered result beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_busy_ff <= 1'b0;
      end else if (rsp_beat) begin
         last_busy_ff <= rsp_payload.busy_res;
      end
   end

   // A stalled result beat holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat changed while stalled");

   // A request can only be turned away while a transaction is running.
   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && rsp_payload.rejected |-> last_busy_ff)
      else $error("request rejected while idle");

   // Completion only ends a transaction that was running.
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && rsp_payload.done_res |-> last_busy_ff && !rsp_payload.busy_res)
      else $error("done without a running transaction");

   // Leaving busy always comes with the done pulse.
   a_idle_done: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && last_busy_ff && !rsp_payload.busy_res |-> rsp_payload.done_res)
      else $error("transaction ended without done");

endmodule

bind i2c_eeprom_master_sequencer_top i2cem_checker u_i2cem_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
